// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned OCC_W   = 5;

  // Operation carried by each input beat.
  typedef enum logic [1:0] {
    FN_APPEND  = 2'd0,
    FN_INSERT  = 2'd1,
    FN_DEQUEUE = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry, value in the low half.
  typedef struct packed {
    logic [FIELD_W-1:0] pri;
    logic [FIELD_W-1:0] val;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch the operand, restart the scan
    logic rd;        // read the entry at the scan position
    logic ins_step;  // one sorted insert step on the read entry
    logic deq_step;  // take the head entry off the queue
    logic tail_wr;   // write at the tail and grow the queue
    logic out_load;  // load the result register
  } spq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;
    logic empty;
    logic last;      // scan position is the last stored entry
  } spq_sts_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// After acceptance a dropped append or insert, an empty dequeue or an unused
// code goes straight to the result; an append or an insert into an empty
// queue writes at the tail; a dequeue reads and takes the head entry; a
// sorted insert does one memory read and compare per stored entry, then the
// tail write. A new input beat is taken once the previous result is loaded.
// Reset (synchronous, rst_n low) empties the queue; entry storage is not reset.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded queue of value/priority pairs with append, sorted insert and
// dequeue operations, one result beat per input beat.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] item_value, [63:32] item_priority
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] head_value, [63:32] head_priority,
                                  // [68:64] occupancy, [71:69] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  spq_cmd_t         cmd;
  spq_sts_t         sts;
  status_t          res_status;
  entry_t           res_entry;
  logic [OCC_W-1:0] res_occ;

  // The controller walks each operation through its states; the datapath
  // keeps the entries in a circular memory addressed from the head pointer.
  // A sorted insert scans from the head. Up to the first entry whose
  // priority is not below the newcomer nothing moves; that slot takes the
  // newcomer, each later slot takes the entry carried from the slot before it,
  // and the last carried entry (or the newcomer, if no entry matched) lands at the tail.
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (func_t'(in_tuser)),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .cmd        (cmd),
    .sts        (sts)
  );

  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_val    (in_tdata[31:0]),
    .in_pri    (in_tdata[63:32]),
    .sts       (sts),
    .res_entry (res_entry),
    .res_occ   (res_occ)
  );

  // The result register holds the beat while the consumer stalls.
  assign out_tdata = {3'b000, res_occ, res_entry.pri, res_entry.val};
  assign out_tuser = res_status;

  // A full and an empty queue at once would mean a corrupted count.
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && sts.empty))
    else $error("queue reports full and empty together");

  // An empty dequeue leaves nothing stored.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (out_tdata[68:64] == '0))
    else $error("empty status with nonzero occupancy");

  // A dropped append or insert only happens at full capacity.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (out_tdata[68:64] == OCC_W'(DEPTH)))
    else $error("full status below capacity");

  // The block works on one beat at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an operation is in progress");

endmodule

// ----- rtl/spq_dpath.sv -----
// ----------------------------------------------------------------------------
// spq_dpath
// Circular entry memory, pointers, scan compare and result register.
// ----------------------------------------------------------------------------
module spq_dpath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_cmd_t            cmd,
  input  logic [FIELD_W-1:0]  in_val,
  input  logic [FIELD_W-1:0]  in_pri,
  output spq_sts_t            sts,
  output entry_t              res_entry,
  output logic [OCC_W-1:0]    res_occ
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  entry_t          rdata_r;
  entry_t          opnd_r;
  entry_t          carry_r;
  entry_t          deq_r;
  entry_t          out_ent_r;
  logic [OCC_W-1:0] out_occ_r;
  logic [AW-1:0]   head_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   scan_r;
  logic            found_r;

  logic [AW-1:0]   rd_idx;
  logic [AW-1:0]   tail_idx;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic            we;
  logic            hit;
  logic [AW-1:0]   head_inc;

  // Queue position to memory slot; the sum stays below twice the depth.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    rd_idx   = slot_of(head_r, scan_r);
    tail_idx = slot_of(head_r, count_r);
    hit      = $signed(rdata_r.pri) >= $signed(opnd_r.pri);
    we       = (cmd.ins_step && (found_r || hit)) || cmd.tail_wr;
    waddr    = cmd.tail_wr ? tail_idx : rd_idx;
    wdata    = found_r ? carry_r : opnd_r;
    head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      scan_r  <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r  <= '0;
        found_r <= 1'b0;
      end
      if (cmd.ins_step) begin
        scan_r <= scan_r + CW'(1);
        if (found_r || hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.deq_step) begin
        head_r  <= head_inc;
        count_r <= count_r - CW'(1);
      end
      if (cmd.tail_wr) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Operand, carried entry and result payload need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r <= '{pri: in_pri, val: in_val};
      deq_r  <= '0;
    end
    if (cmd.ins_step && (found_r || hit)) begin
      carry_r <= rdata_r;
    end
    if (cmd.deq_step) begin
      deq_r <= rdata_r;
    end
    if (cmd.out_load) begin
      out_ent_r <= deq_r;
      out_occ_r <= OCC_W'(count_r);
    end
  end

  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.empty = (count_r == '0);
  assign sts.last  = ((scan_r + CW'(1)) == count_r);

  assign res_entry = out_ent_r;
  assign res_occ   = out_occ_r;

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Operation sequencer and result handshake for the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  func_t    in_func,
  output logic     out_valid,
  input  logic     out_ready,
  output status_t  out_status,
  output spq_cmd_t cmd,
  input  spq_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_TAIL,
    S_FIN
  } state_t;

  state_t  state_r;
  logic    is_deq_r;
  status_t status_r;
  status_t out_status_r;
  logic    out_valid_r;
  logic    accept;
  logic    out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.rd       = (state_r == S_RD);
    cmd.ins_step = (state_r == S_CMP) && !is_deq_r;
    cmd.deq_step = (state_r == S_CMP) && is_deq_r;
    cmd.tail_wr  = (state_r == S_TAIL);
    cmd.out_load = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      is_deq_r     <= 1'b0;
      status_r     <= ST_OK;
      out_status_r <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            is_deq_r <= (in_func == FN_DEQUEUE);
            unique case (in_func)
              FN_APPEND: begin
                if (sts.full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_TAIL;
                end
              end
              FN_INSERT: begin
                if (sts.full) begin
                  status_r <= ST_FULL;
                  state_r  <= S_FIN;
                end else if (sts.empty) begin
                  status_r <= ST_OK;
                  state_r  <= S_TAIL;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_RD;
                end
              end
              FN_DEQUEUE: begin
                if (sts.empty) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_RD;
                end
              end
              FN_NOP: begin
                status_r <= ST_OK;
                state_r  <= S_FIN;
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (is_deq_r) begin
            state_r <= S_FIN;
          end else if (sts.last) begin
            state_r <= S_TAIL;
          end else begin
            state_r <= S_RD;
          end
        end
        S_TAIL: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
